[hw/rtl/sclbu_pkg.sv]
// ----------------------------------------------------------------------------
// sclbu_pkg
// shared constants and types of the script call/loop/branch unit
// ----------------------------------------------------------------------------
package sclbu_pkg;

  localparam int unsigned STACK_LEVELS = 4;
  localparam int unsigned DEPTH_W      = $clog2(STACK_LEVELS + 1);
  localparam int unsigned IDX_W        = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

  localparam logic [7:0] CMD_BRANCH_NEG  = 8'hF2;
  localparam logic [7:0] CMD_BRANCH_ZERO = 8'hF3;
  localparam logic [7:0] CMD_BRANCH      = 8'hF4;
  localparam logic [7:0] CMD_JUMP_NONNEG = 8'hF5;
  localparam logic [7:0] CMD_LOOP_BREAK  = 8'hF6;
  localparam logic [7:0] CMD_LOOP_END    = 8'hF7;
  localparam logic [7:0] CMD_LOOP_START  = 8'hF8;
  localparam logic [7:0] CMD_JUMP_NEG    = 8'hF9;
  localparam logic [7:0] CMD_JUMP_ZERO   = 8'hFA;
  localparam logic [7:0] CMD_JUMP        = 8'hFB;
  localparam logic [7:0] CMD_CALL        = 8'hFC;
  localparam logic [7:0] CMD_DELAY       = 8'hFD;
  localparam logic [7:0] CMD_STOP        = 8'hFE;
  localparam logic [7:0] CMD_END         = 8'hFF;

  localparam logic [2:0] ST_CONTINUE  = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_STOP      = 3'd2;
  localparam logic [2:0] ST_DELAY     = 3'd3;
  localparam logic [2:0] ST_STACK_ERR = 3'd4;

  typedef struct packed {
    logic capture;
    logic commit;
  } sclbu_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic stack_full;
  } sclbu_stat_t;

endpackage

[hw/rtl/sclbu_datapath.sv]
// ----------------------------------------------------------------------------
// sclbu_datapath
// request registers, return stack with loop counters, next pc and result regs
// ----------------------------------------------------------------------------
module sclbu_datapath
  import sclbu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  sclbu_cmd_t  cmd_i,
  input  logic [7:0]  req_type_i,
  input  logic [15:0] arg_i,
  input  logic [31:0] cur_pc_i,
  input  logic [7:0]  cond_value_i,
  output sclbu_stat_t stat_o,
  output logic [31:0] next_pc_o,
  output logic [2:0]  status_o,
  output logic [15:0] delay_value_o
);

  logic [31:0]        base_q;
  logic [7:0]         req_type_q;
  logic [15:0]        arg_q;
  logic [31:0]        cur_pc_q;
  logic [7:0]         cond_q;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [31:0]        ret_stack_q [STACK_LEVELS];
  logic [7:0]         loop_cnt_q  [STACK_LEVELS];
  logic [31:0]        out_pc_q;
  logic [2:0]         out_status_q;
  logic [15:0]        out_delay_q;

  logic               empty, full, neg, zero;
  logic [DEPTH_W-1:0] depth_m1;
  logic [IDX_W-1:0]   top_idx, wr_idx;
  logic [31:0]        jump_target, branch_target;
  logic [7:0]         cnt_dec;
  logic [31:0]        next_pc;
  logic [2:0]         status;
  logic [15:0]        delay_value;
  logic               push, pop, loop_init, cnt_wr;

  assign empty         = (depth_q == '0);
  assign full          = (depth_q == DEPTH_W'(STACK_LEVELS));
  assign neg           = cond_q[7];
  assign zero          = (cond_q == 8'd0);
  assign depth_m1      = depth_q - 1'b1;
  assign top_idx       = depth_m1[IDX_W-1:0];
  assign wr_idx        = depth_q[IDX_W-1:0];
  assign jump_target   = base_q + {16'd0, arg_q};
  assign branch_target = cur_pc_q + {{24{arg_q[7]}}, arg_q[7:0]};
  assign cnt_dec       = loop_cnt_q[top_idx] - 8'd1;

  always_comb begin
    next_pc     = cur_pc_q;
    status      = ST_CONTINUE;
    delay_value = 16'd0;
    push        = 1'b0;
    pop         = 1'b0;
    loop_init   = 1'b0;
    cnt_wr      = 1'b0;
    unique case (req_type_q)
      CMD_END: begin
        if (empty) begin
          status = ST_END;
        end else begin
          pop     = 1'b1;
          next_pc = ret_stack_q[top_idx];
        end
      end
      CMD_STOP: status = ST_STOP;
      CMD_DELAY: begin
        status      = ST_DELAY;
        delay_value = arg_q;
      end
      CMD_CALL: begin
        if (full) begin
          status = ST_STACK_ERR;
        end else begin
          push    = 1'b1;
          next_pc = jump_target;
        end
      end
      CMD_LOOP_START: begin
        if (full) begin
          status = ST_STACK_ERR;
        end else begin
          push      = 1'b1;
          loop_init = 1'b1;
        end
      end
      CMD_LOOP_END: begin
        if (empty) begin
          status = ST_STACK_ERR;
        end else begin
          cnt_wr = 1'b1;
          if (cnt_dec != 8'd0) begin
            next_pc = ret_stack_q[top_idx];
          end else begin
            pop = 1'b1;
          end
        end
      end
      CMD_LOOP_BREAK: begin
        if (empty) begin
          status = ST_STACK_ERR;
        end else begin
          pop = 1'b1;
        end
      end
      CMD_JUMP_NONNEG:  if (!neg) next_pc = jump_target;
      CMD_JUMP_NEG:     if (neg) next_pc = jump_target;
      CMD_JUMP_ZERO:    if (zero) next_pc = jump_target;
      CMD_JUMP:         next_pc = jump_target;
      CMD_BRANCH_NEG:   if (neg) next_pc = branch_target;
      CMD_BRANCH_ZERO:  if (zero) next_pc = branch_target;
      CMD_BRANCH:       next_pc = branch_target;
      default: ;
    endcase
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.commit) begin
      if (push) begin
        depth_d = depth_q + 1'b1;
      end else if (pop) begin
        depth_d = depth_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 32'd0;
      depth_q <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      arg_q      <= arg_i;
      cur_pc_q   <= cur_pc_i;
      cond_q     <= cond_value_i;
    end
    if (cmd_i.commit) begin
      out_pc_q     <= next_pc;
      out_status_q <= status;
      out_delay_q  <= delay_value;
      if (push) begin
        ret_stack_q[wr_idx] <= cur_pc_q;
      end
      if (loop_init) begin
        loop_cnt_q[wr_idx] <= arg_q[7:0];
      end
      if (cnt_wr) begin
        loop_cnt_q[top_idx] <= cnt_dec;
      end
    end
  end

  assign stat_o.stack_empty = empty;
  assign stat_o.stack_full  = full;
  assign next_pc_o          = out_pc_q;
  assign status_o           = out_status_q;
  assign delay_value_o      = out_delay_q;

endmodule

[hw/rtl/sclbu_ctrl.sv]
// ----------------------------------------------------------------------------
// sclbu_ctrl
// request sequencing and result valid tracking
// ----------------------------------------------------------------------------
module sclbu_ctrl
  import sclbu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sclbu_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/script_call_loop_branch_unit_top.sv]
// ----------------------------------------------------------------------------
// script_call_loop_branch_unit_top
// control-flow unit: calls, loops, jumps and branches of a sequence interpreter
// ----------------------------------------------------------------------------
// accept captures a request; the execute step then writes the stack and the result registers
// execute waits while an unread result is held; the next request is accepted only after execute
// the result register lets the next request enter while a result waits
// reset clears stack depth, sequence base and result valid; stack entries are not reset
module script_call_loop_branch_unit_top
  import sclbu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // arg[15:0], cur_pc[47:16], cond_value[55:48]
  input  logic [7:0]  s_axis_tuser,   // req_type[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // next_pc[31:0], delay_value[47:32]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  sclbu_cmd_t  cmd;
  sclbu_stat_t stat;
  logic [31:0] next_pc;
  logic [15:0] delay_value;

  sclbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sclbu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .req_type_i    (s_axis_tuser),
    .arg_i         (s_axis_tdata[15:0]),
    .cur_pc_i      (s_axis_tdata[47:16]),
    .cond_value_i  (s_axis_tdata[55:48]),
    .stat_o        (stat),
    .next_pc_o     (next_pc),
    .status_o      (m_axis_tuser),
    .delay_value_o (delay_value)
  );

  assign m_axis_tdata = {delay_value, next_pc};

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still executing");

  a_commit_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("executed request did not present a result");

  a_stack_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({stat.stack_empty, stat.stack_full}))
    else $error("stack reported empty and full together");

  a_delay_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_DELAY) |-> (delay_value == 16'd0))
    else $error("delay value set on a non-delay result");

endmodule
